### hw/rtl/mac_allow_block_filter_defines.svh
// Assertion macros shared by the MAC allow/block filter RTL.
`ifndef MAC_ALLOW_BLOCK_FILTER_DEFINES_SVH
`define MAC_ALLOW_BLOCK_FILTER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, held off while arst_n is low.
`define MABF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mac filter assertion failed");

// Next-cycle implication, sampled on clk, held off while arst_n is low.
`define MABF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mac filter assertion failed");

`else

`define MABF_ASSERT_IMP(lbl, ante, cons)
`define MABF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/mabf_pkg.sv
// Types and constants shared by the MAC allow/block filter modules.
package mabf_pkg;

	localparam int MAC_W          = 48;
	localparam int KIND_W         = 3;
	localparam int STATUS_W       = 2;
	localparam int LIST_DEPTH_DEF = 64;
	// Table entries held by one cell of the search chain.
	localparam int CELL_ENTRIES   = 8;

	localparam logic [KIND_W-1:0] KIND_CHECK       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADD_BLOCK   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADD_ALLOW   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR_BLOCK = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR_ALLOW = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SKIP = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [MAC_W-1:0]  mac;
	} req_t;

	typedef struct packed {
		logic                allowed;
		logic                on_block_list;
		logic [STATUS_W-1:0] status;
	} res_t;

	// Search token and the hits gathered so far, passed from cell to cell.
	typedef struct packed {
		logic tok;
		logic hit_block;
		logic hit_allow;
	} link_t;

	// Append strobes broadcast to every cell.
	typedef struct packed {
		logic blk_wr;
		logic alw_wr;
	} wr_t;

endpackage

### hw/rtl/mabf_cell.sv
// One search cell: a slice of both tables plus a registered link to the next cell.
module mabf_cell #(
	parameter int LIST_DEPTH = mabf_pkg::LIST_DEPTH_DEF,
	parameter int CELL_BASE  = 0,
	parameter int CNTW       = $clog2(mabf_pkg::LIST_DEPTH_DEF + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mabf_pkg::link_t            link_in,
	output mabf_pkg::link_t            link_out,
	input  logic [mabf_pkg::MAC_W-1:0] mac,
	input  mabf_pkg::wr_t              wr,
	input  logic [CNTW-1:0]            blk_cnt,
	input  logic [CNTW-1:0]            alw_cnt
);

	logic [mabf_pkg::CELL_ENTRIES-1:0] blk_hit;
	logic [mabf_pkg::CELL_ENTRIES-1:0] alw_hit;
	mabf_pkg::link_t                   link_q;

	for (genvar j = 0; j < mabf_pkg::CELL_ENTRIES; j++) begin : g_slot
		localparam int IDX = CELL_BASE + j;
		if (IDX < LIST_DEPTH) begin : g_live
			logic [mabf_pkg::MAC_W-1:0] blk_q;
			logic [mabf_pkg::MAC_W-1:0] alw_q;

			// An append lands in the slot whose index equals the current count.
			always_ff @(posedge clk) begin
				if (wr.blk_wr && (blk_cnt == CNTW'(IDX))) begin
					blk_q <= mac;
				end
				if (wr.alw_wr && (alw_cnt == CNTW'(IDX))) begin
					alw_q <= mac;
				end
			end

			assign blk_hit[j] = (CNTW'(IDX) < blk_cnt) && (blk_q == mac);
			assign alw_hit[j] = (CNTW'(IDX) < alw_cnt) && (alw_q == mac);
		end else begin : g_none
			assign blk_hit[j] = 1'b0;
			assign alw_hit[j] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.tok       <= link_in.tok;
			link_q.hit_block <= link_in.hit_block | (|blk_hit);
			link_q.hit_allow <= link_in.hit_allow | (|alw_hit);
		end
	end

	assign link_out = link_q;

endmodule

### hw/rtl/mac_allow_block_filter.sv
// MAC allow/block list filter: top level with the request register, counts and result logic.
// A taken request sets go_q, then the search token walks the chain of cells, one cell of
// eight entries per cycle; when it leaves the last cell, the result is strobed on done for
// one cycle. busy stays high until then, so a new request is taken only after the last is
// done. The receiver cannot stall results.
// Reset (arst_n low, asynchronous) empties both lists and drops any request in flight.
`include "mac_allow_block_filter_defines.svh"

module mac_allow_block_filter #(
	parameter int LIST_DEPTH = mabf_pkg::LIST_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  mabf_pkg::req_t request,
	output logic           done,
	output mabf_pkg::res_t result
);

	// Number of cells in the chain and width of the list counts.
	localparam int NCELL = (LIST_DEPTH + mabf_pkg::CELL_ENTRIES - 1) / mabf_pkg::CELL_ENTRIES;
	localparam int CNTW  = $clog2(LIST_DEPTH + 1);

	logic            busy_q;
	logic            go_q;
	logic            done_q;
	mabf_pkg::req_t  req_q;
	mabf_pkg::res_t  result_q;
	logic [CNTW-1:0] blk_cnt_q;
	logic [CNTW-1:0] alw_cnt_q;

	mabf_pkg::link_t link [NCELL+1];
	logic [NCELL-1:0] tok_vec;
	mabf_pkg::wr_t    wr;
	mabf_pkg::res_t   res_d;
	logic             accept;
	logic             last_tok;
	logic             allowed;
	logic             blk_full;
	logic             alw_full;

	assign accept = start && !busy_q;

	// The token enters the first cell in the cycle after a request is taken.
	assign link[0] = '{tok: go_q, hit_block: 1'b0, hit_allow: 1'b0};

	for (genvar c = 0; c < NCELL; c++) begin : g_cell
		mabf_cell #(
			.LIST_DEPTH(LIST_DEPTH),
			.CELL_BASE (c * mabf_pkg::CELL_ENTRIES),
			.CNTW      (CNTW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.link_in (link[c]),
			.link_out(link[c+1]),
			.mac     (req_q.mac),
			.wr      (wr),
			.blk_cnt (blk_cnt_q),
			.alw_cnt (alw_cnt_q)
		);
		assign tok_vec[c] = link[c+1].tok;
	end

	// When the token leaves the last cell, the hit flags cover both whole tables.
	assign last_tok = link[NCELL].tok;
	assign blk_full = (blk_cnt_q == CNTW'(LIST_DEPTH));
	assign alw_full = (alw_cnt_q == CNTW'(LIST_DEPTH));

	// An empty allow list admits all but blocked addresses; otherwise only listed ones pass.
	assign allowed = (alw_cnt_q == '0) ? !link[NCELL].hit_block : link[NCELL].hit_allow;

	always_comb begin
		res_d.allowed       = allowed;
		res_d.on_block_list = link[NCELL].hit_block;
		res_d.status        = mabf_pkg::STATUS_DONE;
		wr                  = '0;
		case (req_q.kind)
			mabf_pkg::KIND_ADD_BLOCK: begin
				// The allowed test comes before the full-table test.
				if (!allowed) begin
					res_d.status = mabf_pkg::STATUS_SKIP;
				end else if (blk_full) begin
					res_d.status = mabf_pkg::STATUS_FULL;
				end else begin
					wr.blk_wr = last_tok;
				end
			end
			mabf_pkg::KIND_ADD_ALLOW: begin
				if (alw_full) begin
					res_d.status = mabf_pkg::STATUS_FULL;
				end else begin
					wr.alw_wr = last_tok;
				end
			end
			mabf_pkg::KIND_CLEAR_BLOCK, mabf_pkg::KIND_CLEAR_ALLOW: begin
				res_d.allowed       = 1'b0;
				res_d.on_block_list = 1'b0;
			end
			default: begin
				// A check, or an unused code handled as a check.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			go_q      <= 1'b0;
			done_q    <= 1'b0;
			blk_cnt_q <= '0;
			alw_cnt_q <= '0;
		end else begin
			go_q   <= accept;
			done_q <= last_tok;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last_tok) begin
				busy_q <= 1'b0;
			end
			if (last_tok) begin
				if (req_q.kind == mabf_pkg::KIND_CLEAR_BLOCK) begin
					blk_cnt_q <= '0;
				end else if (wr.blk_wr) begin
					blk_cnt_q <= blk_cnt_q + CNTW'(1);
				end
				if (req_q.kind == mabf_pkg::KIND_CLEAR_ALLOW) begin
					alw_cnt_q <= '0;
				end else if (wr.alw_wr) begin
					alw_cnt_q <= alw_cnt_q + CNTW'(1);
				end
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (last_tok) begin
			result_q <= res_d;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	`MABF_ASSERT_IMP(a_one_token, 1'b1, $onehot0({go_q, tok_vec}))
	`MABF_ASSERT_NEXT(a_token_done, last_tok, done_q && !busy_q)
	`MABF_ASSERT_NEXT(a_accept_busy, accept, busy_q && go_q)
	`MABF_ASSERT_IMP(a_cnt_range, 1'b1, (blk_cnt_q <= CNTW'(LIST_DEPTH)) && (alw_cnt_q <= CNTW'(LIST_DEPTH)))

endmodule

### tb/mac_allow_block_filter_tb.sv
// Self-checking testbench for the MAC allow/block list filter.
module mac_allow_block_filter_tb;

	import mabf_pkg::*;

	localparam int LIST_DEPTH = LIST_DEPTH_DEF;
	// Spacing between two accepted requests, reckoned from the list depth.
	localparam int REQ_SPACING = (LIST_DEPTH + 7) / 8 + 2;
	// Slowest legal gap between two handshakes is the longest sender pause plus
	// REQ_SPACING; the limit leaves a wide margin above that.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAC_POOL_SIZE = 12;
	localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = KIND_CLEAR_ALLOW + 3'd1;

	typedef struct {
		req_t req;
		res_t verdict;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	res_t result;

	// Shadow copy of both lists, updated as requests are accepted.
	logic [MAC_W-1:0] blk_macs [LIST_DEPTH];
	logic [MAC_W-1:0] alw_macs [LIST_DEPTH];
	int blk_fill = 0;
	int alw_fill = 0;

	pending_t expected_verdicts[$];
	logic [MAC_W-1:0] mac_pool [MAC_POOL_SIZE];

	bit gaps_on = 1'b1;
	int mismatches = 0;
	int idle_cycles = 0;
	int n_requests = 0;
	int n_allowed = 0;
	int n_skipped = 0;
	int n_full = 0;

	mac_allow_block_filter #(
		.LIST_DEPTH(LIST_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Works out the verdict for one request from the lists as they stand before
	// it, then applies the request to the shadow lists. Lookups only scan the
	// filled part of each list, so stale entries beyond the fill never matter.
	function automatic res_t predict_verdict(input req_t r);
		res_t v;
		logic on_blk;
		logic on_alw;
		logic pass;
		on_blk = 1'b0;
		on_alw = 1'b0;
		for (int i = 0; i < blk_fill; i++)
			if (blk_macs[i] == r.mac)
				on_blk = 1'b1;
		for (int i = 0; i < alw_fill; i++)
			if (alw_macs[i] == r.mac)
				on_alw = 1'b1;
		// An empty allow list means everything not blocked passes; otherwise
		// only allow-list members pass, whatever the block list says.
		pass = (alw_fill == 0) ? !on_blk : on_alw;
		v.allowed = pass;
		v.on_block_list = on_blk;
		v.status = STATUS_DONE;
		case (r.kind)
			KIND_ADD_BLOCK: begin
				// The allowed test comes before the full-table test.
				if (!pass) begin
					v.status = STATUS_SKIP;
				end else if (blk_fill >= LIST_DEPTH) begin
					v.status = STATUS_FULL;
				end else begin
					blk_macs[blk_fill] = r.mac;
					blk_fill++;
				end
			end
			KIND_ADD_ALLOW: begin
				// Duplicates are kept on the allow list.
				if (alw_fill >= LIST_DEPTH) begin
					v.status = STATUS_FULL;
				end else begin
					alw_macs[alw_fill] = r.mac;
					alw_fill++;
				end
			end
			KIND_CLEAR_BLOCK: begin
				blk_fill = 0;
				v.allowed = 1'b0;
				v.on_block_list = 1'b0;
			end
			KIND_CLEAR_ALLOW: begin
				alw_fill = 0;
				v.allowed = 1'b0;
				v.on_block_list = 1'b0;
			end
			default: begin
				// Checks and the unused kind codes leave the lists alone.
			end
		endcase
		return v;
	endfunction

	// Results are checked before new requests are predicted in the same edge,
	// so the order of the two never matters. Both read the values that stood
	// before the edge, since the block updates its outputs by nonblocking
	// assignment and the stimulus drives start and request the same way.
	always @(posedge clk) begin : result_check
		pending_t head;
		if (arst_n) begin
			if (done) begin
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request pending: ", $time,
							"allowed=%0b on_block=%0b status=%0d",
							result.allowed, result.on_block_list, result.status);
				end else begin
					head = expected_verdicts.pop_front();
					if (result.allowed !== head.verdict.allowed ||
					    result.on_block_list !== head.verdict.on_block_list ||
					    result.status !== head.verdict.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: kind=%0d mac=%h ", $time,
								head.req.kind, head.req.mac,
								"expected allowed=%0b on_block=%0b status=%0d, ",
								head.verdict.allowed, head.verdict.on_block_list,
								head.verdict.status,
								"got allowed=%0b on_block=%0b status=%0d",
								result.allowed, result.on_block_list, result.status);
					end
				end
			end
			if (start && !busy) begin
				head.req = request;
				head.verdict = predict_verdict(request);
				expected_verdicts = {expected_verdicts, head};
				n_requests++;
				if (head.verdict.allowed)
					n_allowed++;
				if (head.verdict.status == STATUS_SKIP)
					n_skipped++;
				if (head.verdict.status == STATUS_FULL)
					n_full++;
			end
		end
	end

	// Ends a hung run: counts edges at which neither a request nor a result
	// moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: nothing moved for %0d cycles", idle_cycles);
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Presents one request and returns at the edge that takes it. start stays
	// high afterwards so that back-to-back requests need no extra step.
	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [MAC_W-1:0] mac);
		start <= 1'b1;
		request <= '{kind: kind, mac: mac};
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Sometimes drops start for a random burst before the next request.
	task automatic sender_pause();
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9))
				@(posedge clk);
		end
	endtask

	// Holds off new requests until every pending result has come back.
	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (REQ_SPACING)
			@(posedge clk);
	endtask

	function automatic logic [MAC_W-1:0] random_mac();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[MAC_W-1:0];
	endfunction

	// Mostly reuses a small pool so that adds and checks hit the same
	// addresses; the rest are fresh addresses that almost never match.
	function automatic logic [MAC_W-1:0] pick_mac();
		if ($urandom_range(0, 9) < 8)
			return mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
		return random_mac();
	endfunction

	// When allow_rare is set, allow-list adds are mostly turned into checks so
	// that the allow list stays empty long enough to exercise the block list.
	function automatic logic [KIND_W-1:0] random_kind(input bit allow_rare);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return KIND_CHECK;
		if (roll < 62)
			return KIND_ADD_BLOCK;
		if (roll < 76)
			return (allow_rare && $urandom_range(0, 3) != 0) ? KIND_CHECK : KIND_ADD_ALLOW;
		if (roll < 82)
			return KIND_CLEAR_BLOCK;
		if (roll < 88)
			return KIND_CLEAR_ALLOW;
		if (roll < 95)
			return KIND_FIRST_UNUSED + 3'($urandom_range(0, 2));
		return KIND_CHECK;
	endfunction

	// Hand-picked walk through every kind and each corner of the filter rules.
	task automatic test_directed_cases();
		logic [MAC_W-1:0] a;
		logic [MAC_W-1:0] b;
		logic [MAC_W-1:0] c;
		logic [MAC_W-1:0] d;
		a = mac_pool[2];
		b = mac_pool[3];
		c = mac_pool[4];
		d = mac_pool[5];
		// Empty tables pass everything, including the extreme addresses.
		send_request(KIND_CHECK, '0);
		send_request(KIND_CHECK, '1);
		// Unused kind codes behave as checks.
		send_request(KIND_FIRST_UNUSED, a);
		send_request(KIND_FIRST_UNUSED + 3'd1, '1);
		send_request(KIND_FIRST_UNUSED + 3'd2, '0);
		// Blocking an address, then trying to block it again is skipped.
		send_request(KIND_ADD_BLOCK, a);
		send_request(KIND_CHECK, a);
		send_request(KIND_ADD_BLOCK, a);
		send_request(KIND_ADD_BLOCK, '1);
		// A clear ignores its address field.
		send_request(KIND_CLEAR_BLOCK, a);
		send_request(KIND_CHECK, a);
		send_request(KIND_ADD_BLOCK, a);
		// A non-empty allow list overrides the block list.
		send_request(KIND_ADD_ALLOW, c);
		send_request(KIND_CHECK, c);
		send_request(KIND_CHECK, d);
		send_request(KIND_CHECK, a);
		send_request(KIND_ADD_BLOCK, d);
		// An allowed address already on the block list is appended once more.
		send_request(KIND_ADD_ALLOW, a);
		send_request(KIND_ADD_BLOCK, a);
		// Duplicate allow-list entries are kept.
		send_request(KIND_ADD_ALLOW, c);
		send_request(KIND_CLEAR_ALLOW, '1);
		send_request(KIND_CHECK, a);
		send_request(KIND_CHECK, b);
		send_request(KIND_CLEAR_BLOCK, '0);
		send_request(KIND_CHECK, a);
	endtask

	// Fills each list to its depth and pushes one add past it.
	task automatic test_table_full();
		logic [MAC_W-1:0] first_blocked;
		logic [MAC_W-1:0] first_allowed;
		first_blocked = random_mac();
		first_allowed = random_mac();
		send_request(KIND_CLEAR_BLOCK, random_mac());
		send_request(KIND_CLEAR_ALLOW, random_mac());
		send_request(KIND_ADD_BLOCK, first_blocked);
		for (int i = 1; i < LIST_DEPTH; i++) begin
			sender_pause();
			send_request(KIND_ADD_BLOCK, random_mac());
		end
		send_request(KIND_ADD_BLOCK, random_mac());
		// A blocked address is skipped before the full test is reached.
		send_request(KIND_ADD_BLOCK, first_blocked);
		send_request(KIND_CHECK, first_blocked);
		send_request(KIND_ADD_ALLOW, first_allowed);
		for (int i = 1; i < LIST_DEPTH; i++) begin
			sender_pause();
			send_request(KIND_ADD_ALLOW, (i % 9 == 0) ? first_allowed : random_mac());
		end
		send_request(KIND_ADD_ALLOW, random_mac());
		send_request(KIND_CHECK, first_allowed);
		// Allowed by the allow list, but the block list has no room.
		send_request(KIND_ADD_BLOCK, first_allowed);
		wait_for_results();
		send_request(KIND_CLEAR_BLOCK, random_mac());
		send_request(KIND_CLEAR_ALLOW, random_mac());
	endtask

	// Random mix of all kinds with random sender gaps; one full drain midway.
	task automatic test_random_mix();
		bit allow_rare;
		allow_rare = 1'b0;
		for (int n = 0; n < 640; n++) begin
			if (n % 40 == 0)
				allow_rare = 1'($urandom_range(0, 1));
			if (n == 320)
				wait_for_results();
			sender_pause();
			send_request(random_kind(allow_rare), pick_mac());
		end
	endtask

	// Closing stretch with start held high the whole time.
	task automatic test_back_to_back();
		gaps_on = 1'b0;
		for (int n = 0; n < 150; n++)
			send_request(random_kind(n >= 75), pick_mac());
	endtask

	initial begin
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		for (int i = 2; i < MAC_POOL_SIZE; i++)
			mac_pool[i] = random_mac();
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_table_full();
		test_random_mix();
		test_back_to_back();
		wait_for_results();
		$display("covered %0d requests: %0d allowed, ", n_requests, n_allowed,
			"%0d skipped block adds, %0d adds dropped on a full list",
			n_skipped, n_full);
		$display("%0d mismatches, %0d results still outstanding", mismatches,
			expected_verdicts.size());
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
